>>> hw/rtl/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg
// Shared widths, codes and limits for the closest points to line core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clp_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = CoordW + 1;
  localparam int DotW    = 2 * DiffW + 1;
  localparam int NumW    = 2 * DotW;
  localparam int ProdW   = NumW + DiffW;
  localparam int MW      = ProdW + 1;
  localparam int DdW     = NumW + 2;
  localparam int QuoW    = CoordW + 3;
  localparam int LimbW   = 34;
  localparam int PartW   = 2 * LimbW;
  localparam int DdHiW   = DotW - LimbW;
  localparam int NdLimbs = (NumW + LimbW - 1) / LimbW;
  localparam int NdTopW  = NumW - (NdLimbs - 1) * LimbW;
  localparam int DivLat  = QuoW + 4;
  localparam int PipeLat = 7 + DivLat;
  localparam int CfgIdxW = 3;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW - 1) {1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW - 1) {1'b0}}};

  typedef enum logic {
    OpPoint = 1'b0,
    OpLines = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegStartX = 3'd0,
    RegStartY = 3'd1,
    RegStartZ = 3'd2,
    RegEndX   = 3'd3,
    RegEndY   = 3'd4,
    RegEndZ   = 3'd5
  } cfg_idx_e;

  function automatic logic signed [2*DiffW-1:0] mul_diff(logic signed [DiffW-1:0] a,
                                                        logic signed [DiffW-1:0] b);
    logic signed [2*DiffW-1:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

>>> hw/rtl/clp_mul_dd.sv
// ----------------------------------------------------------------------------
// clp_mul_dd
// Two-stage signed multiplier for dot-product operands, split into limbs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_mul_dd (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [clp_pkg::DotW-1:0]   a_i,
  input  logic signed [clp_pkg::DotW-1:0]   b_i,
  output logic signed [clp_pkg::NumW-1:0]   p_o
);

  logic        [clp_pkg::LimbW-1:0]  a_lo, b_lo;
  logic signed [clp_pkg::DdHiW-1:0]  a_hi, b_hi;
  logic        [clp_pkg::PartW-1:0]  pll_d, pll_q;
  logic signed [clp_pkg::PartW-1:0]  plh_d, plh_q, phl_d, phl_q, phh_d, phh_q;
  logic signed [clp_pkg::NumW-1:0]   sum_d, p_q;

  assign a_lo = a_i[clp_pkg::LimbW-1:0];
  assign b_lo = b_i[clp_pkg::LimbW-1:0];
  assign a_hi = a_i[clp_pkg::DotW-1:clp_pkg::LimbW];
  assign b_hi = b_i[clp_pkg::DotW-1:clp_pkg::LimbW];

  always_comb begin
    pll_d = a_lo * b_lo;
    plh_d = $signed({1'b0, a_lo}) * b_hi;
    phl_d = a_hi * $signed({1'b0, b_lo});
    phh_d = a_hi * b_hi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= pll_d;
      plh_q <= plh_d;
      phl_q <= phl_d;
      phh_q <= phh_d;
    end
  end

  always_comb begin
    sum_d = clp_pkg::NumW'(pll_q)
          + (clp_pkg::NumW'(plh_q) <<< clp_pkg::LimbW)
          + (clp_pkg::NumW'(phl_q) <<< clp_pkg::LimbW)
          + (clp_pkg::NumW'(phh_q) <<< (2 * clp_pkg::LimbW));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/clp_mul_nd.sv
// ----------------------------------------------------------------------------
// clp_mul_nd
// Two-stage signed multiplier of a wide numerator by a direction component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_mul_nd (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [clp_pkg::NumW-1:0]   a_i,
  input  logic signed [clp_pkg::DiffW-1:0]  b_i,
  output logic signed [clp_pkg::ProdW-1:0]  p_o
);

  logic signed [clp_pkg::PartW-1:0]  pp_d [clp_pkg::NdLimbs];
  logic signed [clp_pkg::PartW-1:0]  pp_q [clp_pkg::NdLimbs];
  logic signed [clp_pkg::NdTopW-1:0] a_top;
  logic signed [clp_pkg::ProdW-1:0]  sum_d, p_q;

  assign a_top = a_i[clp_pkg::NumW-1:(clp_pkg::NdLimbs-1)*clp_pkg::LimbW];

  always_comb begin
    for (int k = 0; k < clp_pkg::NdLimbs - 1; k++) begin
      pp_d[k] = $signed({1'b0, a_i[k*clp_pkg::LimbW +: clp_pkg::LimbW]}) * b_i;
    end
    pp_d[clp_pkg::NdLimbs-1] = a_top * b_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < clp_pkg::NdLimbs; k++) begin
      sum_d = sum_d + (clp_pkg::ProdW'(pp_q[k]) <<< (k * clp_pkg::LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/clp_div.sv
// ----------------------------------------------------------------------------
// clp_div
// Pipelined rounding divider, one quotient bit a stage, with offset and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [clp_pkg::ProdW-1:0]  prod_i,
  input  logic signed [clp_pkg::NumW-1:0]   den_i,
  input  logic signed [clp_pkg::CoordW-1:0] base_i,
  output logic signed [clp_pkg::CoordW-1:0] res_o
);

  localparam int Q = clp_pkg::QuoW;

  logic signed [clp_pkg::MW-1:0]     m0_q;
  logic        [clp_pkg::DdW-1:0]    dd0_q, dd1_q;
  logic signed [clp_pkg::CoordW-1:0] b0_q, b1_q;
  logic        [clp_pkg::MW-1:0]     mm1_d, mm1_q;
  logic                              neg1_q;
  logic        [clp_pkg::MW:0]       flip;

  logic        [clp_pkg::DdW-1:0]    rem_q  [Q+1];
  logic        [Q-1:0]               low_q  [Q+1];
  logic        [Q-1:0]               quo_q  [Q+1];
  logic        [clp_pkg::DdW-1:0]    dd_q   [Q+1];
  logic                              neg_q  [Q+1];
  logic                              ovf_q  [Q+1];
  logic signed [clp_pkg::CoordW-1:0] base_q [Q+1];

  logic        [clp_pkg::DdW-1:0]    hi;
  logic signed [Q:0]                 qs;
  logic signed [Q+1:0]               sum;
  logic signed [clp_pkg::CoordW-1:0] res_d, res_q;

  // 2n + d over 2d
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q  <= (clp_pkg::MW'(prod_i) <<< 1) + clp_pkg::MW'(den_i);
      dd0_q <= clp_pkg::DdW'(den_i) << 1;
      b0_q  <= base_i;
    end
  end

  // negative numerator folds into a floor on the magnitude
  always_comb begin
    flip  = -(clp_pkg::MW + 1)'(m0_q) + (clp_pkg::MW + 1)'(dd0_q) - 1'b1;
    mm1_d = m0_q[clp_pkg::MW-1] ? flip[clp_pkg::MW-1:0] : m0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm1_q  <= mm1_d;
      neg1_q <= m0_q[clp_pkg::MW-1];
      dd1_q  <= dd0_q;
      b1_q   <= b0_q;
    end
  end

  assign hi = clp_pkg::DdW'(mm1_q[clp_pkg::MW-1:Q]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= hi;
      low_q[0]  <= mm1_q[Q-1:0];
      quo_q[0]  <= '0;
      dd_q[0]   <= dd1_q;
      neg_q[0]  <= neg1_q;
      ovf_q[0]  <= (hi >= dd1_q);
      base_q[0] <= b1_q;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [clp_pkg::DdW:0] t, diff;
    logic                  ge;

    always_comb begin
      t    = {rem_q[k], low_q[k][Q-1]};
      diff = t - {1'b0, dd_q[k]};
      ge   = (t >= {1'b0, dd_q[k]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[clp_pkg::DdW-1:0] : t[clp_pkg::DdW-1:0];
        low_q[k+1]  <= low_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][Q-2:0], ge};
        dd_q[k+1]   <= dd_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        base_q[k+1] <= base_q[k];
      end
    end
  end

  always_comb begin
    qs  = neg_q[Q] ? -$signed({1'b0, quo_q[Q]}) : $signed({1'b0, quo_q[Q]});
    sum = (Q + 2)'(base_q[Q]) + (Q + 2)'(qs);
    if (ovf_q[Q]) begin
      res_d = neg_q[Q] ? clp_pkg::CoordMin : clp_pkg::CoordMax;
    end else if (sum > (Q + 2)'(clp_pkg::CoordMax)) begin
      res_d = clp_pkg::CoordMax;
    end else if (sum < (Q + 2)'(clp_pkg::CoordMin)) begin
      res_d = clp_pkg::CoordMin;
    end else begin
      res_d = sum[clp_pkg::CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> hw/rtl/closest_points_to_line_core.sv
// ----------------------------------------------------------------------------
// closest_points_to_line_core
// Point-to-line projection and closest points between two 3-D lines.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        sink       in_valid_i / in_ready_o, operation, query start and end
// out       source     out_valid_o / out_ready_i, degenerate, from and to
// cfg       sink       cfg_we_i, cfg_idx_i, cfg_data_i (no back-pressure)
//
// One beat enters per cycle while no held result stalls the pipeline.
// Depth is set by the 35 quotient stages of the six divider lanes.
// A held result stalls the whole pipeline in place; nothing is dropped.
// Reset clears the reference line and the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_points_to_line_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [clp_pkg::CoordW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_start_x_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_start_y_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_start_z_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_end_x_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_end_y_i,
  input  logic signed [clp_pkg::CoordW-1:0]   query_end_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                degenerate_o,
  output logic signed [clp_pkg::CoordW-1:0]   from_x_o,
  output logic signed [clp_pkg::CoordW-1:0]   from_y_o,
  output logic signed [clp_pkg::CoordW-1:0]   from_z_o,
  output logic signed [clp_pkg::CoordW-1:0]   to_x_o,
  output logic signed [clp_pkg::CoordW-1:0]   to_y_o,
  output logic signed [clp_pkg::CoordW-1:0]   to_z_o
);

  typedef struct {
    clp_pkg::op_e                      op;
    logic signed [clp_pkg::DotW-1:0]   rv;
    logic signed [clp_pkg::DotW-1:0]   vv;
    logic signed [clp_pkg::CoordW-1:0] a [3];
    logic signed [clp_pkg::CoordW-1:0] p [3];
    logic signed [clp_pkg::DiffW-1:0]  v [3];
    logic signed [clp_pkg::DiffW-1:0]  w [3];
  } side_t;

  logic en;

  logic signed [clp_pkg::CoordW-1:0] ref_start_q [3];
  logic signed [clp_pkg::CoordW-1:0] ref_end_q   [3];
  logic signed [clp_pkg::CoordW-1:0] qs_in [3];
  logic signed [clp_pkg::CoordW-1:0] qe_in [3];

  logic                 vld_q [clp_pkg::PipeLat];
  logic                 deg_q [clp_pkg::DivLat];

  // stage 1: differences
  clp_pkg::op_e                      s1_op;
  logic signed [clp_pkg::CoordW-1:0] s1_a [3], s1_p [3];
  logic signed [clp_pkg::DiffW-1:0]  s1_v [3], s1_r [3], s1_w [3];

  // stage 2: dot products
  side_t                             s2, s3, s4;
  logic signed [clp_pkg::DotW-1:0]   s2_vw, s2_rw, s2_ww;
  logic signed [clp_pkg::DotW-1:0]   rv_d, vw_d, rw_d, vv_d, ww_d;

  logic signed [clp_pkg::NumW-1:0]   p_wwvv, p_vwvw, p_rvvw, p_rwvv, p_rvww, p_rwvw;

  // stage 5: numerators and denominator
  logic signed [clp_pkg::NumW-1:0]   den_d, na_d, nb_d;
  logic signed [clp_pkg::NumW-1:0]   s5_den, s5_na, s5_nb, s6_den, s7_den;
  logic                              s5_deg, s6_deg, s7_deg;
  logic signed [clp_pkg::CoordW-1:0] s5_a [3], s5_p [3], s6_a [3], s6_p [3];
  logic signed [clp_pkg::CoordW-1:0] s7_a [3], s7_p [3];
  logic signed [clp_pkg::DiffW-1:0]  s5_v [3], s5_w [3];

  logic signed [clp_pkg::ProdW-1:0]  prod_from [3], prod_to [3];
  logic signed [clp_pkg::CoordW-1:0] res_from [3], res_to [3];

  logic                              out_valid_q, out_deg_q;
  logic signed [clp_pkg::CoordW-1:0] out_from_q [3], out_to_q [3];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign qs_in[0] = query_start_x_i;
  assign qs_in[1] = query_start_y_i;
  assign qs_in[2] = query_start_z_i;
  assign qe_in[0] = query_end_x_i;
  assign qe_in[1] = query_end_y_i;
  assign qe_in[2] = query_end_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ref_start_q[i] <= '0;
        ref_end_q[i]   <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (clp_pkg::cfg_idx_e'(cfg_idx_i))
        clp_pkg::RegStartX: ref_start_q[0] <= cfg_data_i;
        clp_pkg::RegStartY: ref_start_q[1] <= cfg_data_i;
        clp_pkg::RegStartZ: ref_start_q[2] <= cfg_data_i;
        clp_pkg::RegEndX:   ref_end_q[0]   <= cfg_data_i;
        clp_pkg::RegEndY:   ref_end_q[1]   <= cfg_data_i;
        clp_pkg::RegEndZ:   ref_end_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and degenerate flag travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < clp_pkg::PipeLat; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < clp_pkg::PipeLat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[clp_pkg::PipeLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op <= clp_pkg::op_e'(operation_i);
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= ref_start_q[i];
        s1_p[i] <= qs_in[i];
        s1_v[i] <= clp_pkg::DiffW'(ref_end_q[i]) - clp_pkg::DiffW'(ref_start_q[i]);
        s1_r[i] <= clp_pkg::DiffW'(qs_in[i]) - clp_pkg::DiffW'(ref_start_q[i]);
        s1_w[i] <= clp_pkg::DiffW'(qe_in[i]) - clp_pkg::DiffW'(qs_in[i]);
      end
    end
  end

  always_comb begin
    rv_d = '0;
    vw_d = '0;
    rw_d = '0;
    vv_d = '0;
    ww_d = '0;
    for (int i = 0; i < 3; i++) begin
      rv_d = rv_d + clp_pkg::DotW'(clp_pkg::mul_diff(s1_r[i], s1_v[i]));
      vw_d = vw_d + clp_pkg::DotW'(clp_pkg::mul_diff(s1_v[i], s1_w[i]));
      rw_d = rw_d + clp_pkg::DotW'(clp_pkg::mul_diff(s1_r[i], s1_w[i]));
      vv_d = vv_d + clp_pkg::DotW'(clp_pkg::mul_diff(s1_v[i], s1_v[i]));
      ww_d = ww_d + clp_pkg::DotW'(clp_pkg::mul_diff(s1_w[i], s1_w[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2.op <= s1_op;
      s2.rv <= rv_d;
      s2.vv <= vv_d;
      s2.a  <= s1_a;
      s2.p  <= s1_p;
      s2.v  <= s1_v;
      s2.w  <= s1_w;
      s2_vw <= vw_d;
      s2_rw <= rw_d;
      s2_ww <= ww_d;
      s3    <= s2;
      s4    <= s3;
    end
  end

  clp_mul_dd u_mul_wwvv (.clk_i, .en_i(en), .a_i(s2_ww), .b_i(s2.vv), .p_o(p_wwvv));
  clp_mul_dd u_mul_vwvw (.clk_i, .en_i(en), .a_i(s2_vw), .b_i(s2_vw), .p_o(p_vwvw));
  clp_mul_dd u_mul_rvvw (.clk_i, .en_i(en), .a_i(s2.rv), .b_i(s2_vw), .p_o(p_rvvw));
  clp_mul_dd u_mul_rwvv (.clk_i, .en_i(en), .a_i(s2_rw), .b_i(s2.vv), .p_o(p_rwvv));
  clp_mul_dd u_mul_rvww (.clk_i, .en_i(en), .a_i(s2.rv), .b_i(s2_ww), .p_o(p_rvww));
  clp_mul_dd u_mul_rwvw (.clk_i, .en_i(en), .a_i(s2_rw), .b_i(s2_vw), .p_o(p_rwvw));

  // point projection reuses the line path with a zero numerator on the query side
  always_comb begin
    if (s4.op == clp_pkg::OpLines) begin
      den_d = p_wwvv - p_vwvw;
      na_d  = p_rvvw - p_rwvv;
      nb_d  = p_rvww - p_rwvw;
    end else begin
      den_d = clp_pkg::NumW'(s4.vv);
      na_d  = '0;
      nb_d  = clp_pkg::NumW'(s4.rv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_den <= den_d;
      s5_na  <= na_d;
      s5_nb  <= nb_d;
      s5_deg <= (den_d == '0);
      s5_a   <= s4.a;
      s5_p   <= s4.p;
      s5_v   <= s4.v;
      s5_w   <= s4.w;
      s6_den <= s5_den;
      s6_deg <= s5_deg;
      s6_a   <= s5_a;
      s6_p   <= s5_p;
      s7_den <= s6_den;
      s7_deg <= s6_deg;
      s7_a   <= s6_a;
      s7_p   <= s6_p;
      deg_q[0] <= s7_deg;
      for (int i = 1; i < clp_pkg::DivLat; i++) begin
        deg_q[i] <= deg_q[i-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    clp_mul_nd u_mul_from (
      .clk_i, .en_i(en), .a_i(s5_na), .b_i(s5_w[i]), .p_o(prod_from[i])
    );
    clp_mul_nd u_mul_to (
      .clk_i, .en_i(en), .a_i(s5_nb), .b_i(s5_v[i]), .p_o(prod_to[i])
    );
    clp_div u_div_from (
      .clk_i, .en_i(en), .prod_i(prod_from[i]), .den_i(s7_den), .base_i(s7_p[i]),
      .res_o(res_from[i])
    );
    clp_div u_div_to (
      .clk_i, .en_i(en), .prod_i(prod_to[i]), .den_i(s7_den), .base_i(s7_a[i]),
      .res_o(res_to[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_deg_q <= deg_q[clp_pkg::DivLat-1];
      for (int i = 0; i < 3; i++) begin
        out_from_q[i] <= deg_q[clp_pkg::DivLat-1] ? '0 : res_from[i];
        out_to_q[i]   <= deg_q[clp_pkg::DivLat-1] ? '0 : res_to[i];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign degenerate_o = out_deg_q;
  assign from_x_o     = out_from_q[0];
  assign from_y_o     = out_from_q[1];
  assign from_z_o     = out_from_q[2];
  assign to_x_o       = out_to_q[0];
  assign to_y_o       = out_to_q[1];
  assign to_z_o       = out_to_q[2];

endmodule

>>> hw/rtl/clp_port_check.sv
// ----------------------------------------------------------------------------
// clp_port_check
// Port-level checks for the closest points to line core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_port_check (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              degenerate_o,
  input logic signed [clp_pkg::CoordW-1:0] from_x_o,
  input logic signed [clp_pkg::CoordW-1:0] from_y_o,
  input logic signed [clp_pkg::CoordW-1:0] from_z_o,
  input logic signed [clp_pkg::CoordW-1:0] to_x_o,
  input logic signed [clp_pkg::CoordW-1:0] to_y_o,
  input logic signed [clp_pkg::CoordW-1:0] to_z_o
);

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (from_x_o == '0 && from_y_o == '0 &&
      from_z_o == '0 && to_x_o == '0 && to_y_o == '0 && to_z_o == '0))
    else $error("degenerate beat with non-zero coordinates");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output held");

  a_free_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(degenerate_o) &&
      $stable(from_x_o) && $stable(to_z_o)))
    else $error("held output beat changed");

endmodule

bind closest_points_to_line_core clp_port_check u_port_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .degenerate_o (degenerate_o),
  .from_x_o     (from_x_o),
  .from_y_o     (from_y_o),
  .from_z_o     (from_z_o),
  .to_x_o       (to_x_o),
  .to_y_o       (to_y_o),
  .to_z_o       (to_z_o)
);
